### hw/rtl/masked_byte_signature_patcher_assert.svh
// Assertion macros for the signature patcher checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MASKED_BYTE_SIGNATURE_PATCHER_ASSERT_SVH
`define MASKED_BYTE_SIGNATURE_PATCHER_ASSERT_SVH

// Generic property, sampled on the rising clock edge, off during reset.
`define MBSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// A stalled item keeps its valid and the watched payload.
`define MBSP_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) \
    else $error(msg);

`endif

### hw/rtl/mbsp_pkg.sv
// ----------------------------------------------------------------------------
// mbsp_pkg
// Widths, register codes and shared types of the signature patcher.
// ----------------------------------------------------------------------------
package mbsp_pkg;

  localparam int BYTE_W      = 8;
  localparam int MASK_W      = 8;
  localparam int LEN_W       = 4;
  localparam int SKIP_W      = 3;
  localparam int COUNT_W     = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int MAX_LEN_DEF = 8;

  localparam logic [MASK_W-1:0] SIG_CARE_RST = 8'hFF;
  localparam logic [LEN_W-1:0]  SIG_LEN_RST  = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIG_BYTES   = 3'd0,
    REG_SIG_CARE    = 3'd1,
    REG_SIG_LEN     = 3'd2,
    REG_PATCH_BYTES = 3'd3,
    REG_PATCH_WRITE = 3'd4,
    REG_PATCH_LEN   = 3'd5
  } cfg_reg_e;

  // Per-cell control for one cycle
  typedef struct packed {
    logic load;   // take the incoming stream byte
    logic shift;  // take the neighbour's view
    logic patch;  // present the patch byte instead of the held byte
  } cell_ctl_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               out_last;
    logic [COUNT_W-1:0] match_count;
  } out_item_t;

endpackage

### hw/rtl/mbsp_if.sv
// ----------------------------------------------------------------------------
// mbsp_if
// Valid/ready channels of the signature patcher: config, byte in, byte out.
// ----------------------------------------------------------------------------
interface mbsp_cfg_if import mbsp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

interface mbsp_in_if import mbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              in_last;

  modport source (output valid, output data_byte, output in_last, input ready);
  modport sink   (input valid, input data_byte, input in_last, output ready);
endinterface

interface mbsp_out_if import mbsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_byte;
  logic               out_last;
  logic [COUNT_W-1:0] match_count;

  modport source (output valid, output out_byte, output out_last, output match_count,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input match_count,
                  output ready);
endinterface

### hw/rtl/mbsp_cell.sv
// ----------------------------------------------------------------------------
// mbsp_cell
// One window position: holds a byte, compares it, shows it patched or not.
// ----------------------------------------------------------------------------
module mbsp_cell import mbsp_pkg::*; (
  input  logic              clk_i,
  input  cell_ctl_t         ctl_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic [BYTE_W-1:0] next_byte_i,
  input  logic [BYTE_W-1:0] sig_byte_i,
  input  logic              care_i,
  input  logic [BYTE_W-1:0] patch_byte_i,
  output logic [BYTE_W-1:0] view_o,
  output logic              hit_o
);

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] byte_d;

  assign hit_o  = !care_i || (byte_q == sig_byte_i);
  assign view_o = ctl_i.patch ? patch_byte_i : byte_q;

  always_comb begin
    if (ctl_i.load) begin
      byte_d = in_byte_i;
    end else if (ctl_i.shift) begin
      byte_d = next_byte_i;
    end else begin
      byte_d = byte_q;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

### hw/rtl/mbsp_out_buf.sv
// ----------------------------------------------------------------------------
// mbsp_out_buf
// Two-entry output queue; decouples the window from the output ready.
// ----------------------------------------------------------------------------
module mbsp_out_buf import mbsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  out_item_t  item_i,
  output logic       space_o,
  mbsp_out_if.source out_o
);

  localparam int BUF_DEPTH = 2;
  localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

  out_item_t        slot_q [BUF_DEPTH];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign space_o           = (cnt_q != CNT_W'(BUF_DEPTH));
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = slot_q[rd_q].out_byte;
  assign out_o.out_last    = slot_q[rd_q].out_last;
  assign out_o.match_count = slot_q[rd_q].match_count;
  assign pop               = out_o.valid && out_o.ready;

  always_comb begin
    wr_d  = push_i ? !wr_q : wr_q;
    rd_d  = pop ? !rd_q : rd_q;
    cnt_d = cnt_q + CNT_W'(push_i) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/masked_byte_signature_patcher.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_patcher - wildcard byte signature search and patch.
// Throughput 1 byte/cycle unless the output stalls. On the last item the held bytes
// drain at 1/cycle while the output queue has room; input stalls until the final one.
// Reset clears counters and flags and loads register defaults; window bytes stay unknown.
// ----------------------------------------------------------------------------
module masked_byte_signature_patcher import mbsp_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mbsp_cfg_if.sink  cfg_i,
  mbsp_in_if.sink   in_i,
  mbsp_out_if.source out_o
);

  localparam int FILL_W = $clog2(MAX_LEN + 1);

  // Configuration registers
  logic [CFG_DATA_W-1:0] sig_bytes_q;
  logic [MASK_W-1:0]     sig_care_q;
  logic [LEN_W-1:0]      sig_len_q;
  logic [CFG_DATA_W-1:0] patch_bytes_q;
  logic [MASK_W-1:0]     patch_write_q;
  logic [LEN_W-1:0]      patch_len_q;

  // Stream control
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [SKIP_W-1:0]  skip_q, skip_d;
  logic [COUNT_W-1:0] matches_q, matches_d;
  logic               drain_q, drain_d;  // an accepted item may still owe results
  logic               flush_q, flush_d;  // last item taken, emptying the window

  logic [LEN_W-1:0]   n_len;
  logic [LEN_W-1:0]   p_len;
  logic               full;
  logic               emit;
  logic               test;
  logic               match_ok;
  logic               match_fire;
  logic               cnt_inc;
  logic               flush_done;
  logic               accept;
  logic [FILL_W-1:0]  fill_after;
  logic [COUNT_W-1:0] count_out;
  logic               buf_space;
  out_item_t          item;

  logic [BYTE_W-1:0]  view [MAX_LEN];
  logic [BYTE_W-1:0]  nxt  [MAX_LEN];
  logic [MAX_LEN-1:0] hit;
  logic [MAX_LEN-1:0] in_win;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, writes past the list are dropped
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_bytes_q   <= '0;
      sig_care_q    <= SIG_CARE_RST;
      sig_len_q     <= SIG_LEN_RST;
      patch_bytes_q <= '0;
      patch_write_q <= '0;
      patch_len_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SIG_BYTES:   sig_bytes_q   <= cfg_i.data;
        REG_SIG_CARE:    sig_care_q    <= cfg_i.data[MASK_W-1:0];
        REG_SIG_LEN:     sig_len_q     <= cfg_i.data[LEN_W-1:0];
        REG_PATCH_BYTES: patch_bytes_q <= cfg_i.data;
        REG_PATCH_WRITE: patch_write_q <= cfg_i.data[MASK_W-1:0];
        REG_PATCH_LEN:   patch_len_q   <= cfg_i.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Effective lengths: a zero length acts as one, clamp to the window depth;
  // the patch never reaches past the signature.
  // --------------------------------------------------------------------------
  always_comb begin
    if (sig_len_q == '0) begin
      n_len = LEN_W'(1);
    end else if (sig_len_q > LEN_W'(MAX_LEN)) begin
      n_len = LEN_W'(MAX_LEN);
    end else begin
      n_len = sig_len_q;
    end
    p_len = (patch_len_q > n_len) ? n_len : patch_len_q;
  end

  // --------------------------------------------------------------------------
  // Window control
  // Cell 0 holds the oldest byte. With queue room a byte leaves when a full
  // signature is held after an item came in, or while flushing. Only a full
  // window tests its start; after a match the next n-1 starts are passed.
  // --------------------------------------------------------------------------
  assign full       = (LEN_W'(fill_q) >= n_len);
  assign emit       = buf_space && (fill_q != '0) && ((drain_q && full) || flush_q);
  assign test       = emit && full;
  assign match_ok   = &(hit | ~in_win);
  assign match_fire = test && (skip_q == '0) && match_ok;
  assign cnt_inc    = match_fire && (matches_q != '1);
  assign count_out  = matches_q + COUNT_W'(cnt_inc);
  assign flush_done = emit && flush_q && (fill_q == FILL_W'(1));
  assign fill_after = fill_q - FILL_W'(emit);

  // Take a new byte once the previous one's drain ends this cycle; a new
  // stream may start in the cycle its predecessor's final byte leaves.
  assign in_i.ready = (!flush_q || flush_done) &&
                      (!drain_q || (LEN_W'(fill_after) < n_len));
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    fill_d  = fill_after + FILL_W'(accept);
    drain_d = accept || (drain_q && (LEN_W'(fill_after) >= n_len));

    if (accept) begin
      flush_d = in_i.in_last;
    end else if (flush_done) begin
      flush_d = 1'b0;
    end else begin
      flush_d = flush_q;
    end

    if (flush_done) begin
      matches_d = '0;
      skip_d    = '0;
    end else begin
      matches_d = emit ? count_out : matches_q;
      if (!test) begin
        skip_d = skip_q;
      end else if (skip_q != '0) begin
        skip_d = skip_q - SKIP_W'(1);
      end else if (match_ok) begin
        skip_d = SKIP_W'(n_len - LEN_W'(1));
      end else begin
        skip_d = skip_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      skip_q    <= '0;
      matches_q <= '0;
      drain_q   <= 1'b0;
      flush_q   <= 1'b0;
    end else begin
      fill_q    <= fill_d;
      skip_q    <= skip_d;
      matches_q <= matches_d;
      drain_q   <= drain_d;
      flush_q   <= flush_d;
    end
  end

  // --------------------------------------------------------------------------
  // Row of cells: each shifts its (possibly patched) byte towards cell 0 on
  // emit; the incoming byte lands behind the last held one.
  // --------------------------------------------------------------------------
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    localparam logic [LEN_W-1:0] JPOS = LEN_W'(j);
    cell_ctl_t ctl;

    if (j == MAX_LEN - 1) begin : g_tail
      assign nxt[j] = '0;
    end else begin : g_body
      assign nxt[j] = view[j+1];
    end

    assign in_win[j]  = (JPOS < n_len);
    assign ctl.load   = accept && (fill_after == FILL_W'(j));
    assign ctl.shift  = emit;
    assign ctl.patch  = match_fire && (JPOS < p_len) && patch_write_q[j];

    mbsp_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .in_byte_i    (in_i.data_byte),
      .next_byte_i  (nxt[j]),
      .sig_byte_i   (sig_bytes_q[BYTE_W*j +: BYTE_W]),
      .care_i       (sig_care_q[j]),
      .patch_byte_i (patch_bytes_q[BYTE_W*j +: BYTE_W]),
      .view_o       (view[j]),
      .hit_o        (hit[j])
    );
  end

  // --------------------------------------------------------------------------
  // Output queue: the emitted item carries the count after this start's test
  // --------------------------------------------------------------------------
  assign item.out_byte    = view[0];
  assign item.out_last    = flush_done;
  assign item.match_count = count_out;

  mbsp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (emit),
    .item_i  (item),
    .space_o (buf_space),
    .out_o   (out_o)
  );

endmodule

### hw/rtl/masked_byte_signature_patcher_checker.sv
// ----------------------------------------------------------------------------
// masked_byte_signature_patcher_checker
// Port-level checks on the output stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "masked_byte_signature_patcher_assert.svh"

module masked_byte_signature_patcher_checker import mbsp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [BYTE_W-1:0]  out_byte_i,
  input logic               out_last_i,
  input logic [COUNT_W-1:0] match_count_i
);

  logic               out_fire;
  logic               mid_q;   // an item of the current stream has left
  logic [COUNT_W-1:0] prev_q;

  assign out_fire = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= 1'b0;
      prev_q <= '0;
    end else if (out_fire) begin
      mid_q  <= !out_last_i;
      prev_q <= match_count_i;
    end
  end

  `MBSP_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, out_byte_i,
                    "output item changed while stalled")

  `MBSP_ASSERT(a_count_step, (out_fire && mid_q) |-> ((match_count_i == prev_q) ||
               (match_count_i == prev_q + COUNT_W'(1))), "match count jumped within a stream")

  `MBSP_ASSERT(a_count_start, (out_fire && !mid_q) |-> (match_count_i <= COUNT_W'(1)),
               "match count not restarted for a new stream")

endmodule

bind masked_byte_signature_patcher masked_byte_signature_patcher_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .out_last_i    (out_o.out_last),
  .match_count_i (out_o.match_count)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench - masked_byte_signature_patcher
// Feeds byte streams through the patcher under several signature and patch
// settings, predicts every outgoing byte, its last flag and its match count,
// and compares them in order with what the block delivers.
// ----------------------------------------------------------------------------
module testbench import mbsp_pkg::*; ();

  localparam int unsigned MAX_SPAN     = MAX_LEN_DEF;
  localparam int unsigned ITEM_TARGET  = 400;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;  // long back-pressure stretch
  localparam int unsigned SHOWN_FAULTS = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              in_last;
  } byte_item_t;

  typedef logic [BYTE_W-1:0] byte_seq_t [$];

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mbsp_cfg_if cfg_if ();
  mbsp_in_if  in_if ();
  mbsp_out_if out_if ();

  masked_byte_signature_patcher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5;
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copies plus the window, its bytes and the copies at the block's widths
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] sig_value   = '0;
  logic [MASK_W-1:0]     sig_mask    = SIG_CARE_RST;
  logic [LEN_W-1:0]      sig_span    = SIG_LEN_RST;
  logic [CFG_DATA_W-1:0] patch_value = '0;
  logic [MASK_W-1:0]     patch_mask  = '0;
  logic [LEN_W-1:0]      patch_span  = '0;

  logic [BYTE_W-1:0]  held_bytes [MAX_SPAN];
  int unsigned        held_count  = 0;
  int unsigned        skip_left   = 0;
  logic [COUNT_W-1:0] stream_hits = '0;

  out_item_t  expected_bytes [$];  // predicted results, oldest first
  byte_item_t pending_bytes  [$];  // stream bytes waiting for the feeder

  // Bookkeeping shared between the stimulus, the feeder and the checker
  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned bytes_out      = 0;
  int unsigned streams_closed = 0;
  int unsigned hits_total     = 0;
  int unsigned reg_writes     = 0;
  int unsigned mismatches     = 0;
  bit          in_fire        = 1'b0;
  int unsigned src_idle_pct   = 32;
  int unsigned sink_idle_pct  = 32;
  bit          sink_hold      = 1'b0;
  bit          sink_hold_go   = 1'b0;

  // Effective window length: zero acts as one, anything above the maximum clamps
  function automatic int unsigned span_now();
    int unsigned n;
    n = sig_span;
    if (n < 1) n = 1;
    if (n > MAX_SPAN) n = MAX_SPAN;
    return n;
  endfunction

  // Drop the oldest held byte into the expectation store and close the gap
  task automatic release_oldest(input bit closes);
    out_item_t e;
    e.out_byte    = held_bytes[0];
    e.out_last    = closes;
    e.match_count = stream_hits;
    expected_bytes = {expected_bytes, e};
    for (int unsigned j = 1; j < held_count; j++) held_bytes[j-1] = held_bytes[j];
    held_count--;
  endtask

  // Advance the window by one accepted stream byte
  task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic closes);
    int unsigned n;
    int unsigned plen;
    bit          hit;
    n = span_now();
    if (held_count < MAX_SPAN) begin
      held_bytes[held_count] = b;
      held_count++;
    end
    // Test each start position once the window is full; a lowered length may
    // leave several to release in one go
    while (held_count >= n && held_count > 0) begin
      if (skip_left > 0) begin
        skip_left--;
      end else begin
        hit = 1'b1;
        for (int unsigned j = 0; j < n; j++) begin
          if (sig_mask[j] && held_bytes[j] != sig_value[8*j +: 8]) hit = 1'b0;
        end
        if (hit) begin
          // Patch length never reaches past the window
          plen = patch_span;
          if (plen > n) plen = n;
          for (int unsigned j = 0; j < plen; j++) begin
            if (patch_mask[j]) held_bytes[j] = patch_value[8*j +: 8];
          end
          if (stream_hits != '1) stream_hits++;
          skip_left = n - 1;
        end
      end
      release_oldest(closes && held_count == 1);
    end
    // Flush: trailing bytes leave untested, then the stream state starts afresh
    if (closes) begin
      while (held_count > 0) release_oldest(held_count == 1);
      skip_left   = 0;
      stream_hits = '0;
    end
  endtask

  task automatic report_fault(input string what);
    mismatches++;
    if (mismatches <= SHOWN_FAULTS) $display("%0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Checker: everything is sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_channels
    out_item_t want;
    in_fire = rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      // Only write registers while the block is idle (not enforced); take them first
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_reg_e'(cfg_if.index))
          REG_SIG_BYTES:   sig_value   = cfg_if.data;
          REG_SIG_CARE:    sig_mask    = cfg_if.data[MASK_W-1:0];
          REG_SIG_LEN:     sig_span    = cfg_if.data[LEN_W-1:0];
          REG_PATCH_BYTES: patch_value = cfg_if.data;
          REG_PATCH_WRITE: patch_mask  = cfg_if.data[MASK_W-1:0];
          REG_PATCH_LEN:   patch_span  = cfg_if.data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        predict_byte(in_if.data_byte, in_if.in_last);
        items_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        bytes_out++;
        if (out_if.out_last) begin
          streams_closed++;
          hits_total += out_if.match_count;
        end
        if (expected_bytes.size() == 0) begin
          report_fault($sformatf("unexpected result: byte %02h last %0b count %0d",
                                 out_if.out_byte, out_if.out_last, out_if.match_count));
        end else begin
          want = expected_bytes.pop_front();
          if (out_if.out_byte !== want.out_byte || out_if.out_last !== want.out_last ||
              out_if.match_count !== want.match_count) begin
            report_fault($sformatf(
              "result mismatch: expected byte %02h last %0b count %0d, got %02h %0b %0d",
              want.out_byte, want.out_last, want.match_count,
              out_if.out_byte, out_if.out_last, out_if.match_count));
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Feeder: offer the next stream byte at the falling edge once the last one
  // has gone, idling at random
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed_bytes
    byte_item_t nxt;
    if (rst_ni && (!in_if.valid || in_fire)) begin
      if (pending_bytes.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        nxt = pending_bytes.pop_front();
        in_if.valid     <= 1'b1;
        in_if.data_byte <= nxt.data_byte;
        in_if.in_last   <= nxt.in_last;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls plus the long hold-off below
  always @(negedge clk_i) begin : pace_results
    out_if.ready <= rst_ni && !sink_hold && ($urandom_range(99) >= sink_idle_pct);
  end

  // Hold off the result side for a long stretch once asked, counting cycles here
  initial begin : long_hold
    wait (sink_hold_go);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    reg_writes++;
  endtask

  // Change idling rates just after a rising edge, away from the drivers
  task automatic set_pace(input int unsigned src_pct, input int unsigned sink_pct);
    @(posedge clk_i);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
  endtask

  // Hold until every queued byte is taken and every result is back, then let
  // the pipeline settle
  task automatic wait_idle();
    do @(negedge clk_i); while (items_accepted != items_queued || expected_bytes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_bytes(input byte_seq_t seq, input bit closes);
    byte_item_t it;
    @(posedge clk_i);
    foreach (seq[i]) begin
      it.data_byte = seq[i];
      it.in_last   = closes && (i == seq.size() - 1);
      pending_bytes = {pending_bytes, it};
    end
    items_queued += seq.size();
  endtask

  // Build a stream that is mostly signature hits with random wildcard content,
  // some near misses with one byte flipped, and plain noise in between
  task automatic queue_stream(input int unsigned len, input bit closes);
    byte_seq_t seq;
    int unsigned n;
    int          bad;
    int unsigned pick;
    logic [BYTE_W-1:0] b;
    n = span_now();
    while (seq.size() < len) begin
      if (len - seq.size() >= n && $urandom_range(99) < 45) begin
        bad = ($urandom_range(4) == 0) ? int'($urandom_range(n - 1)) : -1;
        for (int j = 0; j < int'(n); j++) begin
          b = sig_mask[j] ? sig_value[8*j +: 8] : BYTE_W'($urandom);
          if (j == bad) b = b ^ BYTE_W'(1 << $urandom_range(BYTE_W - 1));
          seq = {seq, b};
        end
      end else begin
        pick = $urandom_range(n - 1);
        b = ($urandom_range(1) == 1) ? sig_value[8*pick +: 8] : BYTE_W'($urandom);
        seq = {seq, b};
      end
    end
    queue_bytes(seq, closes);
  endtask

  // Write every register, leaning towards the extremes
  task automatic pick_setting();
    logic [CFG_DATA_W-1:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(3))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    write_reg(REG_SIG_BYTES, v);
    v = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       v[MASK_W-1:0] = '0;
      1, 2:    v[MASK_W-1:0] = '1;
      default: ;
    endcase
    write_reg(REG_SIG_CARE, v);
    v = {$urandom, $urandom};
    case ($urandom_range(7))
      0:       v[LEN_W-1:0] = 4'd0;
      1:       v[LEN_W-1:0] = 4'd1;
      2:       v[LEN_W-1:0] = 4'd8;
      3:       v[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
      default: v[LEN_W-1:0] = LEN_W'($urandom_range(1, 8));
    endcase
    write_reg(REG_SIG_LEN, v);
    v = {$urandom, $urandom};
    if ($urandom_range(3) == 0) v = '1;
    write_reg(REG_PATCH_BYTES, v);
    v = {$urandom, $urandom};
    case ($urandom_range(4))
      0:       v[MASK_W-1:0] = '0;
      1:       v[MASK_W-1:0] = '1;
      default: ;
    endcase
    write_reg(REG_PATCH_WRITE, v);
    v = {$urandom, $urandom};
    case ($urandom_range(4))
      0:       v[LEN_W-1:0] = 4'd0;
      1:       v[LEN_W-1:0] = 4'd8;
      2:       v[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
      default: v[LEN_W-1:0] = LEN_W'($urandom_range(0, 8));
    endcase
    write_reg(REG_PATCH_LEN, v);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.in_last   = 1'b0;
    out_if.ready    = 1'b0;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: an all-zero window matches, nothing is patched
    queue_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1);
    wait_idle();

    // Length zero behaves as one byte; an oversize patch clamps to that byte
    write_reg(REG_SIG_BYTES,   64'hFFFF_FFFF_FFFF_FFA5);
    write_reg(REG_SIG_CARE,    64'h0000_0000_0000_0001);
    write_reg(REG_SIG_LEN,     64'h0000_0000_0000_0000);
    write_reg(REG_PATCH_BYTES, 64'h0000_0000_0000_005A);
    write_reg(REG_PATCH_WRITE, 64'h0000_0000_0000_00FF);
    write_reg(REG_PATCH_LEN,   64'h0000_0000_0000_000F);
    queue_bytes('{8'hA5, 8'hA5, 8'h00, 8'hA5}, 1'b1);
    wait_idle();

    // Three-byte signature with a wildcard in the middle: a short stream that
    // cannot match, then back-to-back hits that must not overlap
    write_reg(REG_SIG_BYTES,   64'h0000_0000_0033_5511);
    write_reg(REG_SIG_CARE,    64'h0000_0000_0000_0005);
    write_reg(REG_SIG_LEN,     64'h0000_0000_0000_0003);
    write_reg(REG_PATCH_WRITE, 64'h0000_0000_0000_0001);
    write_reg(REG_PATCH_LEN,   64'h0000_0000_0000_0002);
    queue_bytes('{8'h11, 8'h77}, 1'b1);
    queue_bytes('{8'h11, 8'h77, 8'h33, 8'h11, 8'h11, 8'h33, 8'h11}, 1'b1);
    wait_idle();

    // Lower the length while bytes sit in the window
    write_reg(REG_SIG_LEN, 64'h0000_0000_0000_0008);
    queue_bytes('{8'h11, 8'h00, 8'h33}, 1'b0);
    wait_idle();
    write_reg(REG_SIG_LEN, 64'h0000_0000_0000_0002);
    queue_bytes('{8'h00}, 1'b1);
    wait_idle();

    // Random phases, each under a fresh setting
    phase = 0;
    while (items_queued < ITEM_TARGET) begin
      pick_setting();
      if (phase == 2) begin
        // Stretch with no idling on either side
        set_pace(0, 0);
        repeat (3) queue_stream($urandom_range(10, 25), 1'b1);
        wait_idle();
        set_pace(32, 32);
      end else if (phase == 4) begin
        // Keep offering while the result side is held off, so the input stalls
        set_pace(0, 32);
        sink_hold_go = 1'b1;
        queue_stream(60, 1'b1);
        wait_idle();
        set_pace(32, 32);
      end else if (phase == 1 || $urandom_range(3) == 0) begin
        // Pause mid stream until all results are in, retune, then finish it
        queue_stream($urandom_range(1, 15), 1'b0);
        wait_idle();
        if ($urandom_range(2) == 0) begin
          pick_setting();
        end else begin
          write_reg(REG_SIG_LEN, {60'($urandom), LEN_W'($urandom_range(0, span_now()))});
        end
        queue_stream($urandom_range(1, 15), 1'b1);
        wait_idle();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_stream(($urandom_range(5) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 20), 1'b1);
        end
        wait_idle();
      end
      phase++;
    end

    wait_idle();
    $display("Run covered %0d streams under %0d register writes: %0d bytes in, %0d out.",
             streams_closed, reg_writes, items_accepted, bytes_out);
    $display("Matches found across all streams: %0d, including a %0d-cycle result hold.",
             hits_total, HOLD_CYCLES);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("masked_byte_signature_patcher test passed");
    end else begin
      $display("masked_byte_signature_patcher test failed");
    end
    $finish;
  end

  // Stop a hung run well past the slowest legal finish
  initial begin : run_limit
    #2000000;
    $display("Timed out with %0d results outstanding", expected_bytes.size());
    $display("masked_byte_signature_patcher test failed");
    $finish;
  end

endmodule
